@@ design/obcc_pkg.sv @@
`timescale 1ns / 1ps
package obcc_pkg;

	localparam int unsigned DEF_MAX_HALF_BIN = 32768;
	localparam int unsigned DEF_MAX_KMER     = 1023;

	localparam int unsigned KMER_W  = 10;
	localparam int unsigned HALF_W  = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 32;
	localparam int unsigned CNT_W   = 17;

	localparam logic [KMER_W-1:0] KMER_RESET = KMER_W'(31);
	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(5000);

	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned RES_NW      = $clog2(MAX_RESULTS + 1);
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [0:0] {
		REG_KMER_LEN = 1'b0,
		REG_HALF_BIN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic unique_start;
		logic final_position;
	} pos_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] bin_index;
		logic [CNT_W-1:0] anchor_count;
		logic [CNT_W-1:0] bases_covered;
		logic             last_bin;
	} bin_item_t;

	typedef struct packed {
		logic [RES_NW-1:0]                 count;
		bin_item_t [MAX_RESULTS-1:0]       bin_list;
	} bin_push_t;

endpackage

@@ design/overlapping_bin_coverage_counter_unit.sv @@
`timescale 1ns / 1ps
// Overlapping-bin coverage counter.
// The item channel (item_valid / item_stall / item) takes one reference position
// per cycle while item_stall is low: an anchor flag and a final-position mark.
// Bins are two half-lengths long and start every half-length; each reported bin
// carries its index, its anchor count and its covered-base count on the bin
// channel (bin_valid / bin_stall / bin).
// An item's results are registered in the result queue and leave it one per
// cycle while bin_stall is low, in increasing bin index. Most items cause no
// result or one; a final position causes up to three. Sustained rate is one
// item per cycle while bin_stall is low, set by the four-entry result queue
// that follows the update logic: item_stall rises when fewer than three
// entries are free, so a stalled receiver backs up into the item channel.
// cfg_we / cfg_index / cfg_data write kmer_len (index 0) and half_bin (index 1);
// the user must do so only while the block is idle; the block does not enforce it.
// Reset clears the position, the bin counters and the queue, and sets kmer_len
// to 31 and half_bin to 5000. After a final position the block starts a new
// reference at bin 0 and keeps its registers.
module overlapping_bin_coverage_counter_unit #(
	parameter int unsigned MAX_HALF_BIN = obcc_pkg::DEF_MAX_HALF_BIN,
	parameter int unsigned MAX_KMER     = obcc_pkg::DEF_MAX_KMER
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  obcc_pkg::pos_item_t        item,
	output logic                       bin_valid,
	input  logic                       bin_stall,
	output obcc_pkg::bin_item_t        bin,
	input  logic                       cfg_we,
	input  obcc_pkg::cfg_reg_t         cfg_index,
	input  logic [obcc_pkg::CFG_W-1:0] cfg_data
);
	import obcc_pkg::*;

	bin_push_t push;
	logic      accept;

	assign accept = item_valid && !item_stall;

	obcc_core #(
		.MAX_HALF_BIN (MAX_HALF_BIN),
		.MAX_KMER     (MAX_KMER)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pos       (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push)
	);

	obcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (item_stall),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin       (bin)
	);

endmodule

@@ design/obcc_core.sv @@
`timescale 1ns / 1ps
module obcc_core #(
	parameter int unsigned MAX_HALF_BIN = obcc_pkg::DEF_MAX_HALF_BIN,
	parameter int unsigned MAX_KMER     = obcc_pkg::DEF_MAX_KMER
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  obcc_pkg::pos_item_t     pos,
	input  logic                    cfg_we,
	input  obcc_pkg::cfg_reg_t      cfg_index,
	input  logic [obcc_pkg::CFG_W-1:0] cfg_data,
	output obcc_pkg::bin_push_t     push
);
	import obcc_pkg::*;

	localparam int unsigned OFF_W = (MAX_HALF_BIN > 1) ? $clog2(MAX_HALF_BIN) : 1;
	localparam int unsigned HB_W  = $clog2(MAX_HALF_BIN + 1);
	localparam int unsigned CD_W  = $clog2(MAX_KMER + 1);

	logic [KMER_W-1:0] kmer_len_q;
	logic [HALF_W-1:0] half_bin_q;

	logic [OFF_W-1:0] off_q;
	logic [IDX_W-1:0] half_q;
	logic [CNT_W-1:0] anc_q  [2];
	logic [CNT_W-1:0] base_q [2];
	logic [CD_W-1:0]  cd_q   [2];

	logic [CNT_W-1:0] anc_d  [2];
	logic [CNT_W-1:0] base_d [2];
	logic [CD_W-1:0]  cd_d   [2];

	logic [CD_W-1:0] k;
	logic [HB_W-1:0] hb;
	logic            end_half;
	logic            cur;
	logic            has_prev;
	bin_item_t       prv_bin, cur_bin, trail_bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q <= KMER_RESET;
			half_bin_q <= HALF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KMER_LEN: kmer_len_q <= cfg_data[KMER_W-1:0];
				REG_HALF_BIN: half_bin_q <= cfg_data[HALF_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		if (32'(kmer_len_q) > 32'(MAX_KMER))
			k = CD_W'(MAX_KMER);
		else
			k = CD_W'(kmer_len_q);
		if (half_bin_q == '0)
			hb = HB_W'(1);
		else if (32'(half_bin_q) > 32'(MAX_HALF_BIN))
			hb = HB_W'(MAX_HALF_BIN);
		else
			hb = HB_W'(half_bin_q);
	end

	assign end_half = ((HB_W + 1)'(off_q) + (HB_W + 1)'(1)) >= (HB_W + 1)'(hb);
	assign cur      = half_q[0];
	assign has_prev = (half_q != '0);

	// Update both open bins; the slot of the current half restarts at its first position.
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			anc_d[s]  = anc_q[s];
			base_d[s] = base_q[s];
			cd_d[s]   = cd_q[s];
			if (off_q == '0 && cur == 1'(s)) begin
				anc_d[s]  = '0;
				base_d[s] = '0;
				cd_d[s]   = '0;
			end
			if (cur == 1'(s) || has_prev) begin
				if (pos.unique_start) begin
					anc_d[s] = anc_d[s] + CNT_W'(1);
					cd_d[s]  = k;
				end
				if (cd_d[s] != '0) begin
					base_d[s] = base_d[s] + CNT_W'(1);
					cd_d[s]   = cd_d[s] - CD_W'(1);
				end
			end
		end
	end

	always_comb begin
		prv_bin.bin_index     = half_q - IDX_W'(1);
		prv_bin.anchor_count  = anc_d[~cur];
		prv_bin.bases_covered = base_d[~cur];
		prv_bin.last_bin      = 1'b0;

		cur_bin.bin_index     = half_q;
		cur_bin.anchor_count  = anc_d[cur];
		cur_bin.bases_covered = base_d[cur];
		cur_bin.last_bin      = ~end_half;

		trail_bin.bin_index     = half_q + IDX_W'(1);
		trail_bin.anchor_count  = '0;
		trail_bin.bases_covered = '0;
		trail_bin.last_bin      = 1'b1;

		push.bin_list = {trail_bin, trail_bin, trail_bin};
		push.count = '0;
		if (accept) begin
			if (has_prev && (end_half || pos.final_position)) begin
				push.bin_list[0] = prv_bin;
				push.bin_list[1] = cur_bin;
				push.count   = pos.final_position
					? (end_half ? RES_NW'(3) : RES_NW'(2)) : RES_NW'(1);
			end else if (pos.final_position) begin
				push.bin_list[0] = cur_bin;
				push.count   = end_half ? RES_NW'(2) : RES_NW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			half_q <= '0;
			for (int s = 0; s < 2; s++) begin
				anc_q[s]  <= '0;
				base_q[s] <= '0;
				cd_q[s]   <= '0;
			end
		end else if (accept) begin
			if (pos.final_position) begin
				off_q  <= '0;
				half_q <= '0;
				for (int s = 0; s < 2; s++) begin
					anc_q[s]  <= '0;
					base_q[s] <= '0;
					cd_q[s]   <= '0;
				end
			end else begin
				if (end_half) begin
					off_q  <= '0;
					half_q <= half_q + IDX_W'(1);
				end else begin
					off_q <= off_q + OFF_W'(1);
				end
				for (int s = 0; s < 2; s++) begin
					anc_q[s]  <= anc_d[s];
					base_q[s] <= base_d[s];
					cd_q[s]   <= cd_d[s];
				end
			end
		end
	end

endmodule

@@ design/obcc_queue.sv @@
`timescale 1ns / 1ps
module obcc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  obcc_pkg::bin_push_t   push,
	output logic                  full,
	output logic                  bin_valid,
	input  logic                  bin_stall,
	output obcc_pkg::bin_item_t   bin
);
	import obcc_pkg::*;

	bin_item_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               pop;

	// Leave room for the largest burst an item can cause.
	assign full      = count_q > QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
	assign bin_valid = (count_q != '0);
	assign bin       = entries_q[rd_ptr_q];
	assign pop       = bin_valid && !bin_stall;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (RES_NW'(i) < push.count)
				entries_q[wr_ptr_q + QPTR_W'(i)] <= push.bin_list[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule
